@@ rtl/cld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types, codes and the power-on sequence table for the character-LCD
// parallel bus driver.
// ----------------------------------------------------------------------------
package cld_pkg;

   localparam int DELAY_WIDTH_DEF = 24;
   localparam int US_WIDTH        = 14;
   localparam int TPU_WIDTH       = 10;
   localparam int PROD_WIDTH      = US_WIDTH + TPU_WIDTH;
   localparam int INIT_STEPS      = 10;

   localparam logic       FOUR_BIT_RST = 1'b1;
   localparam logic [9:0] TICKS_RST    = 10'(100000000 / 1000000);
   localparam logic [9:0] GAP_RST      = 10'd300;

   localparam logic [1:0] MODE_INSTR = 2'd0;
   localparam logic [1:0] MODE_DATA  = 2'd1;
   localparam logic [1:0] MODE_INIT  = 2'd2;

   localparam logic [1:0] CSR_FOUR_BIT = 2'd0;
   localparam logic [1:0] CSR_TICKS    = 2'd1;
   localparam logic [1:0] CSR_GAP      = 2'd2;

   typedef enum logic [4:0] {
      PH_IDLE        = 5'd0,
      PH_POLL_SETUP  = 5'd1,
      PH_POLL_SAMPLE = 5'd2,
      PH_PULSE_A     = 5'd3,
      PH_PULSE_B     = 5'd4,
      PH_PULSE_C     = 5'd5,
      PH_WR_SETUP    = 5'd6,
      PH_STB_DATA    = 5'd7,
      PH_STB_HIGH    = 5'd8,
      PH_STB_LOW     = 5'd9,
      PH_GAP         = 5'd10,
      PH_INIT_DELAY  = 5'd11,
      PH_RAW_SET     = 5'd12,
      PH_RAW_HIGH    = 5'd13,
      PH_RAW_LOW     = 5'd14,
      PH_DISPATCH    = 5'd15
   } phase_type;

   typedef enum logic [1:0] {
      ST_DELAY = 2'd0,
      ST_RAW   = 2'd1,
      ST_INSTR = 2'd2
   } step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [US_WIDTH-1:0]   arg;
   } init_entry_type;

   typedef struct packed {
      logic       four_bit_bus;
      logic [9:0] ticks_per_microsecond;
      logic [9:0] nibble_gap_us;
   } cfg_type;

   typedef struct packed {
      logic       start_req;
      logic [1:0] mode;
      logic [7:0] byte_in;
      logic       busy_in;
   } req_type;

   typedef struct packed {
      logic       e;
      logic       rs;
      logic       rw;
      logic [7:0] data;
      logic       db7_drv;
   } pins_type;

   typedef struct packed {
      pins_type pins;
      logic     ready;
   } rsp_type;

   function automatic init_entry_type init_entry(logic four, logic [3:0] idx);
      init_entry_type ent;
      ent = '{kind: ST_INSTR, arg: 14'h06};
      case (idx)
         4'd0: ent = '{kind: ST_DELAY, arg: 14'd15000};
         4'd1: ent = '{kind: ST_RAW,   arg: 14'h30};
         4'd2: ent = '{kind: ST_DELAY, arg: 14'd4100};
         4'd3: ent = '{kind: ST_RAW,   arg: 14'h30};
         4'd4: ent = '{kind: ST_DELAY, arg: 14'd100};
         4'd5: ent = four ? '{kind: ST_INSTR, arg: 14'h32} : '{kind: ST_RAW, arg: 14'h30};
         4'd6: ent = four ? '{kind: ST_INSTR, arg: 14'h28} : '{kind: ST_INSTR, arg: 14'h38};
         4'd7: ent = '{kind: ST_INSTR, arg: 14'h08};
         4'd8: ent = '{kind: ST_INSTR, arg: 14'h01};
         4'd9: ent = '{kind: ST_INSTR, arg: 14'h06};
         default: ent = '{kind: ST_INSTR, arg: 14'h06};
      endcase
      return ent;
   endfunction

endpackage

@@ rtl/cld_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_seq
// Bus sequencer: phase, delay counter, held byte, init step and pin levels.
// Advances one tick per step strobe and presents the pins after that tick.
// ----------------------------------------------------------------------------
module cld_seq #(
   parameter int DELAY_WIDTH = cld_pkg::DELAY_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  cld_pkg::req_type req,
   input  cld_pkg::cfg_type cfg,
   output cld_pkg::rsp_type rsp_next
);
   import cld_pkg::*;

   localparam int WIDE = (DELAY_WIDTH > PROD_WIDTH) ? DELAY_WIDTH : PROD_WIDTH;

   phase_type              phase_ff, phase_in;
   logic [DELAY_WIDTH-1:0] delay_ff, delay_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_select_ff, held_select_in;
   logic [3:0]             init_step_ff, init_step_in;
   logic                   second_ff, second_in;
   pins_type               pins_ff, pins_in;

   logic [3:0]             init_idx;
   init_entry_type         ent;
   logic [US_WIDTH-1:0]    mul_us;
   logic [PROD_WIDTH-1:0]  product;
   logic [WIDE-1:0]        prod_wide;
   logic [WIDE-1:0]        lim_wide;
   logic [DELAY_WIDTH-1:0] delay_load;
   logic                   delay_done;

   assign init_idx  = 4'(init_step_ff - 4'd1);
   assign ent       = init_entry(cfg.four_bit_bus, init_idx);
   assign mul_us    = (phase_ff == PH_STB_LOW) ? US_WIDTH'(cfg.nibble_gap_us) : ent.arg;
   assign product   = PROD_WIDTH'(mul_us) * PROD_WIDTH'(cfg.ticks_per_microsecond);
   assign prod_wide = WIDE'(product);
   assign lim_wide  = WIDE'({DELAY_WIDTH{1'b1}});
   assign delay_load = (prod_wide > lim_wide) ? {DELAY_WIDTH{1'b1}}
                                              : prod_wide[DELAY_WIDTH-1:0];
   assign delay_done = (delay_ff <= DELAY_WIDTH'(1));

   always_comb begin
      phase_in       = phase_ff;
      delay_in       = delay_ff;
      held_byte_in   = held_byte_ff;
      held_select_in = held_select_ff;
      init_step_in   = init_step_ff;
      second_in      = second_ff;
      pins_in        = pins_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (req.start_req) begin
               if (req.mode inside {MODE_INSTR, MODE_DATA}) begin
                  held_byte_in   = req.byte_in;
                  held_select_in = (req.mode == MODE_DATA);
                  init_step_in   = 4'd0;
                  phase_in       = PH_POLL_SETUP;
               end else if (req.mode == MODE_INIT) begin
                  init_step_in = 4'd1;
                  phase_in     = PH_DISPATCH;
               end
            end
         end
         PH_POLL_SETUP: begin
            pins_in.db7_drv = 1'b0;
            pins_in.rw      = 1'b1;
            pins_in.rs      = 1'b0;
            pins_in.e       = 1'b1;
            phase_in        = PH_POLL_SAMPLE;
         end
         PH_POLL_SAMPLE: begin
            pins_in.e = 1'b0;
            if (req.busy_in) begin
               phase_in = PH_PULSE_A;
            end else begin
               pins_in.db7_drv = 1'b1;
               phase_in        = PH_WR_SETUP;
            end
         end
         PH_PULSE_A: begin
            pins_in.e = 1'b1;
            phase_in  = PH_PULSE_B;
         end
         PH_PULSE_B: begin
            pins_in.e = 1'b0;
            phase_in  = PH_PULSE_C;
         end
         PH_PULSE_C: begin
            pins_in.e = 1'b1;
            phase_in  = PH_POLL_SAMPLE;
         end
         PH_WR_SETUP: begin
            pins_in.rw = 1'b0;
            pins_in.rs = held_select_ff;
            second_in  = 1'b0;
            phase_in   = PH_STB_DATA;
         end
         PH_STB_DATA: begin
            if (cfg.four_bit_bus) begin
               pins_in.data = second_ff ? {held_byte_ff[3:0], 4'h0}
                                        : {held_byte_ff[7:4], 4'h0};
            end else begin
               pins_in.data = held_byte_ff;
            end
            pins_in.e = 1'b0;
            phase_in  = PH_STB_HIGH;
         end
         PH_STB_HIGH: begin
            pins_in.e = 1'b1;
            phase_in  = PH_STB_LOW;
         end
         PH_STB_LOW: begin
            pins_in.e = 1'b0;
            if (cfg.four_bit_bus) begin
               delay_in = delay_load;
               phase_in = PH_GAP;
            end else begin
               phase_in = (init_step_ff == 4'd0) ? PH_IDLE : PH_DISPATCH;
            end
         end
         PH_GAP: begin
            if (delay_done) begin
               delay_in = '0;
               if (!second_ff) begin
                  second_in = 1'b1;
                  phase_in  = PH_STB_DATA;
               end else begin
                  second_in = 1'b0;
                  phase_in  = (init_step_ff == 4'd0) ? PH_IDLE : PH_DISPATCH;
               end
            end else begin
               delay_in = delay_ff - DELAY_WIDTH'(1);
            end
         end
         PH_INIT_DELAY: begin
            if (delay_done) begin
               delay_in = '0;
               phase_in = PH_DISPATCH;
            end else begin
               delay_in = delay_ff - DELAY_WIDTH'(1);
            end
         end
         PH_RAW_SET: begin
            pins_in.rw   = 1'b0;
            pins_in.rs   = 1'b0;
            pins_in.data = cfg.four_bit_bus ? {held_byte_ff[7:4], 4'h0} : held_byte_ff;
            pins_in.e    = 1'b0;
            phase_in     = PH_RAW_HIGH;
         end
         PH_RAW_HIGH: begin
            pins_in.e = 1'b1;
            phase_in  = PH_RAW_LOW;
         end
         PH_RAW_LOW: begin
            pins_in.e = 1'b0;
            phase_in  = PH_DISPATCH;
         end
         PH_DISPATCH: begin
            if (init_step_ff == 4'd0 || init_step_ff > 4'(INIT_STEPS)) begin
               init_step_in = 4'd0;
               phase_in     = PH_IDLE;
            end else begin
               init_step_in = 4'(init_step_ff + 4'd1);
               case (ent.kind)
                  ST_DELAY: begin
                     delay_in = delay_load;
                     phase_in = PH_INIT_DELAY;
                  end
                  ST_RAW: begin
                     held_byte_in   = ent.arg[7:0];
                     held_select_in = 1'b0;
                     phase_in       = PH_RAW_SET;
                  end
                  default: begin
                     held_byte_in   = ent.arg[7:0];
                     held_select_in = 1'b0;
                     phase_in       = PH_POLL_SETUP;
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_next.pins  = pins_in;
      rsp_next.ready = (phase_in == PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         delay_ff       <= '0;
         held_byte_ff   <= '0;
         held_select_ff <= 1'b0;
         init_step_ff   <= '0;
         second_ff      <= 1'b0;
         pins_ff        <= '{e: 1'b0, rs: 1'b0, rw: 1'b0, data: 8'h00, db7_drv: 1'b1};
      end else if (step) begin
         phase_ff       <= phase_in;
         delay_ff       <= delay_in;
         held_byte_ff   <= held_byte_in;
         held_select_ff <= held_select_in;
         init_step_ff   <= init_step_in;
         second_ff      <= second_in;
         pins_ff        <= pins_in;
      end
   end

endmodule

@@ rtl/char_lcd_parallel_bus_driver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_parallel_bus_driver
// Character-LCD parallel bus driver: busy polling, byte and nibble writes and
// the power-on initialise sequence, one sequencer tick per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat is one sequencer tick. start_req with mode asks for an
//            instruction write, a data write or the initialise sequence and is
//            taken only while idle; busy_in is the DB7 level for this tick.
//   rsp_*  : one beat per request beat, the bus pin levels after that tick
//            and ready_res, high when the sequencer is idle again.
//   csr_*  : register writes (bus width, ticks per microsecond, nibble gap),
//            always ready; user issues them while sequencer idle, unenforced.
// Each response beat is registered and offered in the cycle after its request
// beat; one beat is taken every cycle the response register is free, which it
// is as its beat is taken; stalled receivers hold off requests, no beat dropped.
// Delays count request beats: us * ticks_per_microsecond, saturated to
// the delay counter width.
// Reset clears the sequencer to idle with all pins low and DB7 driven, and
// restores register defaults: four-bit bus, 100 ticks per us, 300 us gap.
// ----------------------------------------------------------------------------
module char_lcd_parallel_bus_driver #(
   parameter int DELAY_WIDTH = cld_pkg::DELAY_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_start_req,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_byte_in,
   input  logic       req_busy_in,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_lcd_enable,
   output logic       rsp_lcd_register_select,
   output logic       rsp_lcd_read_write,
   output logic [7:0] rsp_lcd_data_out,
   output logic       rsp_db7_driven,
   output logic       rsp_ready_res,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_data
);
   import cld_pkg::*;

   cfg_type cfg_ff;
   req_type req;
   rsp_type rsp_next;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    accept;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign req = '{start_req: req_start_req, mode: req_mode,
                  byte_in: req_byte_in, busy_in: req_busy_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{four_bit_bus: FOUR_BIT_RST, ticks_per_microsecond: TICKS_RST,
                     nibble_gap_us: GAP_RST};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOUR_BIT: cfg_ff.four_bit_bus          <= csr_data[0];
            CSR_TICKS:    cfg_ff.ticks_per_microsecond <= csr_data;
            CSR_GAP:      cfg_ff.nibble_gap_us         <= csr_data;
            default:      cfg_ff                       <= cfg_ff;
         endcase
      end
   end

   cld_seq #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .req      (req),
      .cfg      (cfg_ff),
      .rsp_next (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_lcd_enable          = rsp_ff.pins.e;
   assign rsp_lcd_register_select = rsp_ff.pins.rs;
   assign rsp_lcd_read_write      = rsp_ff.pins.rw;
   assign rsp_lcd_data_out        = rsp_ff.pins.data;
   assign rsp_db7_driven          = rsp_ff.pins.db7_drv;
   assign rsp_ready_res           = rsp_ff.ready;

endmodule

@@ dv/lcd_bus_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_bus_checker
// Watches the request, response and register channels of the character-LCD
// bus driver. Every accepted request beat is run through a local model of
// the bus sequencer, and the pin levels it predicts are queued. Each
// accepted response beat is compared field by field against the oldest
// queued prediction. fail_count carries mismatches, unexpected beats and
// predictions still waiting.
// ----------------------------------------------------------------------------
module lcd_bus_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_start_req,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_byte_in,
   input  logic        req_busy_in,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_lcd_enable,
   input  logic        rsp_lcd_register_select,
   input  logic        rsp_lcd_read_write,
   input  logic [7:0]  rsp_lcd_data_out,
   input  logic        rsp_db7_driven,
   input  logic        rsp_ready_res,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data,

   output logic [31:0] fail_count
);
   import cld_pkg::*;

   localparam int DLY_W = DELAY_WIDTH_DEF;

   // register copy
   logic             cfg_four;
   logic [9:0]       cfg_tpu;
   logic [9:0]       cfg_gap;

   // sequencer copy
   phase_type        seq_phase;
   logic [DLY_W-1:0] dly_cnt;
   logic [7:0]       hold_byte;
   logic             hold_rs;
   logic [3:0]       boot_step;
   logic             low_half;
   logic             pin_e;
   logic             pin_rs;
   logic             pin_rw;
   logic [7:0]       pin_data;
   logic             pin_drv;

   rsp_type          pins_q[$];
   rsp_type          seen;
   rsp_type          want;
   rsp_type          next_pins;
   int               fault_count = 0;
   int               pending_beats = 0;

   assign fail_count = fault_count + pending_beats;

   function automatic logic [DLY_W-1:0] span_ticks(input logic [13:0] us,
                                                   input logic [9:0] tpu);
      logic [31:0] prod;
      prod = 32'(us) * 32'(tpu);
      if (prod > 32'((64'd1 << DLY_W) - 64'd1))
         return {DLY_W{1'b1}};
      return prod[DLY_W-1:0];
   endfunction

   task count_down(output logic done);
      if (dly_cnt > 1) begin
         dly_cnt = dly_cnt - 1'b1;
         done    = 1'b0;
      end else begin
         dly_cnt = '0;
         done    = 1'b1;
      end
   endtask

   task tick_bus(input logic start, input logic [1:0] mode, input logic [7:0] byte_v,
                 input logic busy);
      logic          done;
      step_kind_type kind;
      logic [13:0]   arg;
      logic [3:0]    idx;
      case (seq_phase)
         PH_IDLE: begin
            if (start) begin
               if (mode == MODE_INSTR || mode == MODE_DATA) begin
                  hold_byte = byte_v;
                  hold_rs   = (mode == MODE_DATA);
                  boot_step = '0;
                  seq_phase = PH_POLL_SETUP;
               end else if (mode == MODE_INIT) begin
                  boot_step = 4'd1;
                  seq_phase = PH_DISPATCH;
               end
            end
         end
         PH_POLL_SETUP: begin
            pin_drv   = 1'b0;
            pin_rw    = 1'b1;
            pin_rs    = 1'b0;
            pin_e     = 1'b1;
            seq_phase = PH_POLL_SAMPLE;
         end
         PH_POLL_SAMPLE: begin
            pin_e = 1'b0;
            if (busy) begin
               seq_phase = PH_PULSE_A;
            end else begin
               pin_drv   = 1'b1;
               seq_phase = PH_WR_SETUP;
            end
         end
         PH_PULSE_A: begin
            pin_e     = 1'b1;
            seq_phase = PH_PULSE_B;
         end
         PH_PULSE_B: begin
            pin_e     = 1'b0;
            seq_phase = PH_PULSE_C;
         end
         PH_PULSE_C: begin
            pin_e     = 1'b1;
            seq_phase = PH_POLL_SAMPLE;
         end
         PH_WR_SETUP: begin
            pin_rw    = 1'b0;
            pin_rs    = hold_rs;
            low_half  = 1'b0;
            seq_phase = PH_STB_DATA;
         end
         PH_STB_DATA: begin
            if (cfg_four)
               pin_data = low_half ? {hold_byte[3:0], 4'h0} : {hold_byte[7:4], 4'h0};
            else
               pin_data = hold_byte;
            pin_e     = 1'b0;
            seq_phase = PH_STB_HIGH;
         end
         PH_STB_HIGH: begin
            pin_e     = 1'b1;
            seq_phase = PH_STB_LOW;
         end
         PH_STB_LOW: begin
            pin_e = 1'b0;
            if (cfg_four) begin
               dly_cnt   = span_ticks(14'(cfg_gap), cfg_tpu);
               seq_phase = PH_GAP;
            end else begin
               seq_phase = (boot_step == 0) ? PH_IDLE : PH_DISPATCH;
            end
         end
         PH_GAP: begin
            count_down(done);
            if (done) begin
               if (!low_half) begin
                  low_half  = 1'b1;
                  seq_phase = PH_STB_DATA;
               end else begin
                  low_half  = 1'b0;
                  seq_phase = (boot_step == 0) ? PH_IDLE : PH_DISPATCH;
               end
            end
         end
         PH_INIT_DELAY: begin
            count_down(done);
            if (done)
               seq_phase = PH_DISPATCH;
         end
         PH_RAW_SET: begin
            pin_rw    = 1'b0;
            pin_rs    = 1'b0;
            pin_data  = cfg_four ? {hold_byte[7:4], 4'h0} : hold_byte;
            pin_e     = 1'b0;
            seq_phase = PH_RAW_HIGH;
         end
         PH_RAW_HIGH: begin
            pin_e     = 1'b1;
            seq_phase = PH_RAW_LOW;
         end
         PH_RAW_LOW: begin
            pin_e     = 1'b0;
            seq_phase = PH_DISPATCH;
         end
         PH_DISPATCH: begin
            if (boot_step == 0 || boot_step > INIT_STEPS) begin
               boot_step = '0;
               seq_phase = PH_IDLE;
            end else begin
               idx = boot_step - 1'b1;
               // power-on: wait, 30h, wait, 30h, wait, two by width, 08h, 01h, 06h
               case (idx)
                  4'd0: begin kind = ST_DELAY; arg = 14'd15000; end
                  4'd1: begin kind = ST_RAW;   arg = 14'h30;    end
                  4'd2: begin kind = ST_DELAY; arg = 14'd4100;  end
                  4'd3: begin kind = ST_RAW;   arg = 14'h30;    end
                  4'd4: begin kind = ST_DELAY; arg = 14'd100;   end
                  4'd5: begin
                     kind = cfg_four ? ST_INSTR : ST_RAW;
                     arg  = cfg_four ? 14'h32 : 14'h30;
                  end
                  4'd6: begin kind = ST_INSTR; arg = cfg_four ? 14'h28 : 14'h38; end
                  4'd7: begin kind = ST_INSTR; arg = 14'h08; end
                  4'd8: begin kind = ST_INSTR; arg = 14'h01; end
                  default: begin kind = ST_INSTR; arg = 14'h06; end
               endcase
               boot_step = boot_step + 1'b1;
               if (kind == ST_DELAY) begin
                  dly_cnt   = span_ticks(arg, cfg_tpu);
                  seq_phase = PH_INIT_DELAY;
               end else begin
                  hold_byte = arg[7:0];
                  hold_rs   = 1'b0;
                  seq_phase = (kind == ST_RAW) ? PH_RAW_SET : PH_POLL_SETUP;
               end
            end
         end
         default: seq_phase = PH_IDLE;
      endcase
      next_pins.pins.e       = pin_e;
      next_pins.pins.rs      = pin_rs;
      next_pins.pins.rw      = pin_rw;
      next_pins.pins.data    = pin_data;
      next_pins.pins.db7_drv = pin_drv;
      next_pins.ready        = (seq_phase == PH_IDLE);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_four  = FOUR_BIT_RST;
         cfg_tpu   = TICKS_RST;
         cfg_gap   = GAP_RST;
         seq_phase = PH_IDLE;
         dly_cnt   = '0;
         hold_byte = '0;
         hold_rs   = 1'b0;
         boot_step = '0;
         low_half  = 1'b0;
         pin_e     = 1'b0;
         pin_rs    = 1'b0;
         pin_rw    = 1'b0;
         pin_data  = '0;
         pin_drv   = 1'b1;
         pins_q.delete();
         pending_beats = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FOUR_BIT: cfg_four = csr_data[0];
               CSR_TICKS:    cfg_tpu  = csr_data;
               CSR_GAP:      cfg_gap  = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen.pins.e       = rsp_lcd_enable;
            seen.pins.rs      = rsp_lcd_register_select;
            seen.pins.rw      = rsp_lcd_read_write;
            seen.pins.data    = rsp_lcd_data_out;
            seen.pins.db7_drv = rsp_db7_driven;
            seen.ready        = rsp_ready_res;
            if (pins_q.size() == 0) begin
               fault_count = fault_count + 1;
               if (fault_count <= 10)
                  $display("%0t: unexpected rsp beat: e=%0b rs=%0b rw=%0b d=%02h drv=%0b rdy=%0b",
                           $realtime, seen.pins.e, seen.pins.rs, seen.pins.rw,
                           seen.pins.data, seen.pins.db7_drv, seen.ready);
            end else begin
               want = pins_q.pop_front();
               if (seen !== want) begin
                  fault_count = fault_count + 1;
                  if (fault_count <= 10) begin
                     $write("%0t: rsp mismatch: exp e=%0b rs=%0b rw=%0b d=%02h drv=%0b rdy=%0b",
                            $realtime, want.pins.e, want.pins.rs, want.pins.rw,
                            want.pins.data, want.pins.db7_drv, want.ready);
                     $display(", got e=%0b rs=%0b rw=%0b d=%02h drv=%0b rdy=%0b",
                              seen.pins.e, seen.pins.rs, seen.pins.rw,
                              seen.pins.data, seen.pins.db7_drv, seen.ready);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            tick_bus(req_start_req, req_mode, req_byte_in, req_busy_in);
            pins_q.push_back(next_pins);
         end
         pending_beats = pins_q.size();
      end
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the character-LCD bus driver. A directed part runs
// one write at the default bus width and tick rate, then instruction and data
// writes with and without busy polling, ignored requests and both power-on
// sequences at the extremes of bus width, tick rate and nibble gap. A random
// part follows with fresh register settings per phase. Both channels idle at
// random up to the last random phases; lcd_bus_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import cld_pkg::*;

   localparam logic [1:0] MODE_NONE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_start_req = 1'b0;
   logic [1:0]  req_mode = MODE_INSTR;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_busy_in = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_lcd_enable;
   logic        rsp_lcd_register_select;
   logic        rsp_lcd_read_write;
   logic [7:0]  rsp_lcd_data_out;
   logic        rsp_db7_driven;
   logic        rsp_ready_res;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_FOUR_BIT;
   logic [9:0]  csr_data = 10'd0;

   logic [31:0] fail_count;

   int          req_beats = 0;
   int          rsp_beats = 0;
   int          last_start = 0;
   logic        last_idle = 1'b1;
   int          snd_idle_pct = 37;
   int          rsp_idle_pct = 45;
   int          busy_pct = 0;
   int          cur_tpu = 100;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   char_lcd_parallel_bus_driver u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_start_req           (req_start_req),
      .req_mode                (req_mode),
      .req_byte_in             (req_byte_in),
      .req_busy_in             (req_busy_in),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_lcd_enable          (rsp_lcd_enable),
      .rsp_lcd_register_select (rsp_lcd_register_select),
      .rsp_lcd_read_write      (rsp_lcd_read_write),
      .rsp_lcd_data_out        (rsp_lcd_data_out),
      .rsp_db7_driven          (rsp_db7_driven),
      .rsp_ready_res           (rsp_ready_res),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   lcd_bus_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_start_req           (req_start_req),
      .req_mode                (req_mode),
      .req_byte_in             (req_byte_in),
      .req_busy_in             (req_busy_in),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_lcd_enable          (rsp_lcd_enable),
      .rsp_lcd_register_select (rsp_lcd_register_select),
      .rsp_lcd_read_write      (rsp_lcd_read_write),
      .rsp_lcd_data_out        (rsp_lcd_data_out),
      .rsp_db7_driven          (rsp_db7_driven),
      .rsp_ready_res           (rsp_ready_res),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .fail_count              (fail_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats <= rsp_beats + 1;
         last_idle <= rsp_ready_res;
      end
   end

   // idle once a response at or after the last start beat reports ready
   function automatic logic known_idle();
      return last_idle && (rsp_beats >= last_start);
   endfunction

   // every beat answered and the last one still busy: next beat is ignored
   function automatic logic known_busy();
      return !last_idle && (rsp_beats == req_beats);
   endfunction

   task send_beat(input logic start, input logic [1:0] mode, input logic [7:0] data_b);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      req_mode      <= mode;
      req_byte_in   <= data_b;
      req_busy_in   <= ($urandom_range(99) < busy_pct);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_beats = req_beats + 1;
      if (start)
         last_start = req_beats;
   endtask

   // tick with no new work; requests here are either ignored or mode three
   task send_filler();
      if (known_busy())
         send_beat(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom));
      else if ($urandom_range(3) == 0)
         send_beat(1'b1, MODE_NONE, 8'($urandom));
      else
         send_beat(1'b0, 2'($urandom_range(3)), 8'($urandom));
   endtask

   task wait_idle();
      while (!known_idle()) send_filler();
   endtask

   task run_op(input logic [1:0] mode, input logic [7:0] data_b);
      wait_idle();
      send_beat(1'b1, mode, data_b);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (rsp_beats != req_beats) @(posedge clock);
   endtask

   task csr_beat(input logic [1:0] idx, input logic [9:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task set_cfg(input logic four, input logic [9:0] tpu, input logic [9:0] gap);
      wait_idle();
      drain();
      csr_beat(CSR_FOUR_BIT, {9'd0, four});
      csr_beat(CSR_TICKS, tpu);
      csr_beat(CSR_GAP, gap);
      csr_valid <= 1'b0;
      cur_tpu = tpu;
   endtask

   initial begin
      int         pick;
      int         sel;
      logic       boot_used;
      logic [9:0] tpu;
      logic [9:0] gap;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default bus width and tick rate, short nibble gaps
      csr_beat(CSR_GAP, 10'd1);
      csr_valid <= 1'b0;
      run_op(MODE_DATA, 8'hC3);

      set_cfg(1'b0, 10'd0, 10'd0);
      run_op(MODE_INSTR, 8'h00);
      run_op(MODE_DATA, 8'hFF);
      busy_pct = 70;
      run_op(MODE_INSTR, 8'h81);
      wait_idle();
      busy_pct = 0;
      run_op(MODE_NONE, 8'h55);
      run_op(MODE_INIT, 8'h00);

      set_cfg(1'b1, 10'd0, 10'd0);
      run_op(MODE_DATA, 8'hA5);
      busy_pct = 50;
      run_op(MODE_INSTR, 8'h0F);
      wait_idle();
      busy_pct = 0;
      run_op(MODE_INIT, 8'h12);

      set_cfg(1'b1, 10'd1023, 10'd0);
      run_op(MODE_DATA, 8'h3C);

      set_cfg(1'b1, 10'd0, 10'd1023);
      run_op(MODE_INSTR, 8'hF0);

      set_cfg(1'b1, 10'd3, 10'd5);
      run_op(MODE_DATA, 8'h5A);

      set_cfg(1'b0, 10'd1023, 10'd1023);
      run_op(MODE_DATA, 8'h96);
      run_op(MODE_INSTR, 8'h69);

      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 4) begin
            snd_idle_pct = 45;
            rsp_idle_pct <= 37;
         end
         if (ph == 8) begin
            snd_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         sel = $urandom_range(9);
         if (sel == 0) begin
            tpu = 10'd1023;
            gap = 10'd0;
         end else if (sel == 1) begin
            tpu = 10'd0;
            gap = 10'($urandom_range(1023));
         end else begin
            tpu = 10'($urandom_range(3));
            gap = 10'($urandom_range(10));
         end
         set_cfg(1'($urandom_range(1)), tpu, gap);
         busy_pct  = $urandom_range(60);
         boot_used = 1'b0;
         repeat (60) begin
            if (known_idle() && $urandom_range(9) < 6) begin
               pick = $urandom_range(9);
               if (pick == 0 && cur_tpu == 0 && !boot_used) begin
                  boot_used = 1'b1;
                  send_beat(1'b1, MODE_INIT, 8'($urandom));
               end else if (pick == 1) begin
                  send_beat(1'b1, MODE_NONE, 8'($urandom));
               end else begin
                  send_beat(1'b1, $urandom_range(1) ? MODE_DATA : MODE_INSTR,
                            8'($urandom));
               end
            end else begin
               send_filler();
            end
         end
      end

      wait_idle();
      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #400_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
